@@ hdl/key_event_queue_with_dedup_defines.svh @@
// Assertion macros used by the key event queue.
// The macros expect clk and rst_n to be in scope.
`ifndef KEY_EVENT_QUEUE_WITH_DEDUP_DEFINES_SVH
`define KEY_EVENT_QUEUE_WITH_DEDUP_DEFINES_SVH

// Condition holds at every edge outside reset.
`define KEVQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define KEVQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent at the next edge.
`define KEVQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/kevq_pkg.sv @@
package kevq_pkg;

  localparam int KEY_W   = 8;
  localparam int EVENT_W = KEY_W + 1;

  // Item operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Push outcome codes.
  localparam logic [1:0] ST_QUEUED  = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_EVICTED = 2'd3;

  // Command bundle from the sequencer to the key-down map.
  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_key;
    logic             wr_en;
    logic [KEY_W-1:0] wr_key;
    logic             wr_down;
  } map_cmd_t;

endpackage

@@ hdl/key_event_queue_with_dedup.sv @@
// Key event queue with duplicate suppression. A push item (op 0) reports a
// key code and its new state; it is ignored when the key-down map already
// holds that state or the code is outside the map, a press is dropped when
// the ring is full, and a release on a full ring evicts the oldest event
// before it is queued, so at most QUEUE_DEPTH-1 events are held. A pop item
// (op 1) returns the oldest event or reports empty. The accept cycle issues
// the synchronous read of the key-down map (push) or of the event ring at
// the read pointer (pop), and the exec state checks, writes both memories
// back on a push that is stored and loads the result register. One item is in
// flight at a time, so a new item is taken only once the last is done; the exec
// state stretches while the result register still holds an untaken result.
// The key-down map is cleared at reset through one valid flop per key, so
// there is no clearing pass and the block takes items right after reset.
`include "key_event_queue_with_dedup_defines.svh"

module key_event_queue_with_dedup #(
  parameter int QUEUE_DEPTH = 64,
  parameter int KEY_COUNT   = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic                       in_key_down,
  input  logic [kevq_pkg::KEY_W-1:0] in_key_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_push_status,
  output logic                       out_event_valid,
  output logic                       out_event_pressed,
  output logic [kevq_pkg::KEY_W-1:0] out_event_key
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                          state_r;
  logic                            op_r;
  logic                            down_r;
  logic [kevq_pkg::KEY_W-1:0]      code_r;
  logic [PTR_W-1:0]                wp_r;
  logic [PTR_W-1:0]                rp_r;
  logic                            out_valid_r;
  logic [1:0]                      out_push_status_r;
  logic                            out_event_valid_r;
  logic                            out_event_pressed_r;
  logic [kevq_pkg::KEY_W-1:0]      out_event_key_r;

  logic                            accept;
  logic                            commit;
  logic                            in_range;
  logic                            map_down;
  logic [kevq_pkg::EVENT_W-1:0]    ring_q;
  logic [PTR_W-1:0]                wp_next;
  logic [PTR_W-1:0]                rp_next;
  logic                            full;
  logic                            empty;
  logic                            push_write;
  logic                            pop_take;
  logic [1:0]                      status_nxt;
  kevq_pkg::map_cmd_t              map_cmd;

  // Take an item only when nothing is in flight.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Finish the item once the result register is free or being emptied.
  assign commit = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign wp_next = (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
  assign rp_next = (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
  assign full    = (wp_next == rp_r);
  assign empty   = (wp_r == rp_r);

  assign in_range = ({1'b0, code_r} < (kevq_pkg::KEY_W + 1)'(KEY_COUNT));

  // Decide the push outcome from the map state read back this cycle.
  always_comb begin
    push_write = 1'b0;
    status_nxt = kevq_pkg::ST_QUEUED;
    priority if (!in_range || (map_down == down_r)) begin
      status_nxt = kevq_pkg::ST_IGNORED;
    end else if (full && down_r) begin
      status_nxt = kevq_pkg::ST_DROPPED;
    end else if (full) begin
      push_write = 1'b1;
      status_nxt = kevq_pkg::ST_EVICTED;
    end else begin
      push_write = 1'b1;
    end
  end

  assign pop_take = (op_r == kevq_pkg::OP_POP) && !empty;

  // Read the map when the code is in range; write it back on a queued push.
  always_comb begin
    map_cmd.rd_en   = accept && (in_op == kevq_pkg::OP_PUSH) &&
                      ({1'b0, in_key_code} < (kevq_pkg::KEY_W + 1)'(KEY_COUNT));
    map_cmd.rd_key  = in_key_code;
    map_cmd.wr_en   = commit && (op_r == kevq_pkg::OP_PUSH) && push_write;
    map_cmd.wr_key  = code_r;
    map_cmd.wr_down = down_r;
  end

  kevq_keymap #(
    .KEY_COUNT (KEY_COUNT)
  ) u_keymap (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (map_cmd),
    .key_down (map_down)
  );

  // Event ring: read the oldest entry on every pop accept.
  kevq_ram #(
    .WIDTH (kevq_pkg::EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (map_cmd.wr_en),
    .wr_addr (wp_r),
    .wr_data ({down_r, code_r}),
    .rd_en   (accept && (in_op == kevq_pkg::OP_POP)),
    .rd_addr (rp_r),
    .rd_data (ring_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
          if (!out_stall) begin
            out_valid_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            if (op_r == kevq_pkg::OP_PUSH) begin
              if (push_write) begin
                wp_r <= wp_next;
                // Evict the oldest event to make room for a release.
                if (full) begin
                  rp_r <= rp_next;
                end
              end
            end else if (pop_take) begin
              rp_r <= rp_next;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Item and result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      down_r <= in_key_down;
      code_r <= in_key_code;
    end
    if (commit) begin
      if (op_r == kevq_pkg::OP_PUSH) begin
        out_push_status_r   <= status_nxt;
        out_event_valid_r   <= 1'b0;
        out_event_pressed_r <= 1'b0;
        out_event_key_r     <= '0;
      end else begin
        out_push_status_r   <= kevq_pkg::ST_QUEUED;
        out_event_valid_r   <= pop_take;
        out_event_pressed_r <= pop_take & ring_q[kevq_pkg::KEY_W];
        out_event_key_r     <= pop_take ? ring_q[kevq_pkg::KEY_W-1:0] : '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_push_status   = out_push_status_r;
  assign out_event_valid   = out_event_valid_r;
  assign out_event_pressed = out_event_pressed_r;
  assign out_event_key     = out_event_key_r;

  `KEVQ_ASSERT_NEXT(a_nonempty_after_write, map_cmd.wr_en, wp_r != rp_r, "ring empty after write")
  `KEVQ_ASSERT_NEXT(a_ptr_hold_on_wait, (state_r == S_EXEC) && !commit, $stable(wp_r) && $stable(rp_r), "pointers moved while waiting")
  `KEVQ_ASSERT_ALWAYS(a_ptr_range, (wp_r <= PTR_W'(QUEUE_DEPTH - 1)) && (rp_r <= PTR_W'(QUEUE_DEPTH - 1)), "pointer out of range")
  `KEVQ_ASSERT_SAME(a_pop_result_clean, out_valid_r && out_event_valid_r, out_push_status_r == kevq_pkg::ST_QUEUED, "pop result carries push status")

endmodule

@@ hdl/kevq_ram.sv @@
module kevq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/kevq_keymap.sv @@
module kevq_keymap #(
  parameter int KEY_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kevq_pkg::map_cmd_t cmd,
  output logic              key_down
);

  localparam int AW = $clog2(KEY_COUNT);

  logic [KEY_COUNT-1:0] valid_r;
  logic [AW-1:0]        rd_addr_r;
  logic [0:0]           ram_q;

  kevq_ram #(
    .WIDTH (1),
    .DEPTH (KEY_COUNT)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_key[AW-1:0]),
    .wr_data (cmd.wr_down),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_key[AW-1:0]),
    .rd_data (ram_q)
  );

  // An entry never written since reset reads as released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[cmd.wr_key[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_addr_r <= cmd.rd_key[AW-1:0];
    end
  end

  assign key_down = valid_r[rd_addr_r] & ram_q[0];

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for the key event queue with duplicate suppression.
// Items are queued up front, then sent one per handshake. Each accepted item
// goes through a cycle-free copy of the queue that predicts its result. The
// monitor checks every accepted result against the oldest prediction, one
// field at a time.
module tb_top;

  localparam int QUEUE_DEPTH = 64;
  localparam int KEY_COUNT   = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QUIET_LIMIT = 2000;

  // One stimulus item. hold_for_drain keeps it back until every
  // earlier result has been taken.
  typedef struct {
    logic                       op;
    logic                       key_down;
    logic [kevq_pkg::KEY_W-1:0] key_code;
    logic                       hold_for_drain;
  } key_item_t;

  typedef struct {
    logic [1:0]                 status;
    logic                       ev_valid;
    logic                       ev_pressed;
    logic [kevq_pkg::KEY_W-1:0] ev_key;
  } key_outcome_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic                       in_op       = kevq_pkg::OP_PUSH;
  logic                       in_key_down = 1'b0;
  logic [kevq_pkg::KEY_W-1:0] in_key_code = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  logic [1:0]                 out_push_status;
  logic                       out_event_valid;
  logic                       out_event_pressed;
  logic [kevq_pkg::KEY_W-1:0] out_event_key;

  key_event_queue_with_dedup #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_COUNT  (KEY_COUNT)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_key_down      (in_key_down),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_push_status  (out_push_status),
    .out_event_valid  (out_event_valid),
    .out_event_pressed(out_event_pressed),
    .out_event_key    (out_event_key)
  );

  // Items still to send, and the results predicted for items already sent.
  key_item_t    key_items[$];
  key_outcome_t expected_outcomes[$];

  // Mirror of the queue state, advanced once per accepted item.
  logic [kevq_pkg::EVENT_W-1:0] ring_copy [QUEUE_DEPTH];
  logic [PTR_W-1:0]             wr_ptr_copy;
  logic [PTR_W-1:0]             rd_ptr_copy;
  logic                         key_map_copy [KEY_COUNT];

  // The generator's guess of which keys are down; used only to bias
  // pushes toward real state changes.
  logic intent_down [KEY_COUNT];

  int items_sent    = 0;
  int results_taken = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int send_gap      = 0;
  int send_mode     = 0;
  int stall_left    = 0;
  int take_mode     = 0;
  key_outcome_t want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one item to the mirror and return the result it must produce.
  function automatic key_outcome_t apply_key_item(input logic op, input logic down,
                                                  input logic [kevq_pkg::KEY_W-1:0] code);
    key_outcome_t     res;
    logic [PTR_W-1:0] nxt;
    res.status     = kevq_pkg::ST_QUEUED;
    res.ev_valid   = 1'b0;
    res.ev_pressed = 1'b0;
    res.ev_key     = '0;
    if (op == kevq_pkg::OP_PUSH) begin
      if (int'(code) >= KEY_COUNT || key_map_copy[code] == down) begin
        res.status = kevq_pkg::ST_IGNORED;
      end else begin
        nxt = wr_ptr_copy + 1'b1;
        if (nxt == rd_ptr_copy && down) begin
          res.status = kevq_pkg::ST_DROPPED;
        end else begin
          // A release on a full ring makes room by dropping the oldest event.
          if (nxt == rd_ptr_copy) begin
            rd_ptr_copy = rd_ptr_copy + 1'b1;
            res.status  = kevq_pkg::ST_EVICTED;
          end
          key_map_copy[code]     = down;
          ring_copy[wr_ptr_copy] = {down, code};
          wr_ptr_copy            = nxt;
        end
      end
    end else if (rd_ptr_copy != wr_ptr_copy) begin
      {res.ev_pressed, res.ev_key} = ring_copy[rd_ptr_copy];
      res.ev_valid = 1'b1;
      rd_ptr_copy  = rd_ptr_copy + 1'b1;
    end
    return res;
  endfunction

  // Idle lengths: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mode 0 never idles, mode 1 idles lightly, mode 2 heavily.
  function automatic bit starts_gap(input int mode);
    if (mode == 0) return 1'b0;
    if (mode == 1) return $urandom_range(0, 99) < 15;
    return $urandom_range(0, 99) < 45;
  endfunction

  task automatic add_item(input logic op, input logic down,
                          input logic [kevq_pkg::KEY_W-1:0] code, input logic hold);
    key_item_t it;
    it.op             = op;
    it.key_down       = down;
    it.key_code       = code;
    it.hold_for_drain = hold;
    key_items.push_back(it);
  endtask

  // Driver: predict on acceptance, then hold, idle or advance to the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      wr_ptr_copy <= '0;
      rd_ptr_copy <= '0;
      for (int k = 0; k < KEY_COUNT; k++) key_map_copy[k] <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(apply_key_item(in_op, in_key_down, in_key_code));
        items_sent <= items_sent + 1;
      end
      // Hold the payload while stalled; otherwise pick what goes out next.
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 149) == 0) send_mode = $urandom_range(0, 2);
        if (send_gap == 0 && starts_gap(send_mode)) send_gap = pick_gap();
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (key_items.size() > 0 &&
                     !(key_items[0].hold_for_drain &&
                       (in_valid || items_sent != results_taken))) begin
          in_op       <= key_items[0].op;
          in_key_down <= key_items[0].key_down;
          in_key_code <= key_items[0].key_code;
          in_valid    <= 1'b1;
          void'(key_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result, then decide whether to stall the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_taken <= results_taken + 1;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item outstanding: status %0d event %0d/%0d/%0d",
                   $time, out_push_status, out_event_valid, out_event_pressed,
                   out_event_key);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_push_status !== want.status) begin
            mismatches++;
            $display("%0t: push_status expected %0d got %0d", $time, want.status,
                     out_push_status);
          end
          if (out_event_valid !== want.ev_valid) begin
            mismatches++;
            $display("%0t: event_valid expected %0d got %0d", $time, want.ev_valid,
                     out_event_valid);
          end
          if (out_event_pressed !== want.ev_pressed) begin
            mismatches++;
            $display("%0t: event_pressed expected %0d got %0d", $time, want.ev_pressed,
                     out_event_pressed);
          end
          if (out_event_key !== want.ev_key) begin
            mismatches++;
            $display("%0t: event_key expected %0d got %0d", $time, want.ev_key,
                     out_event_key);
          end
        end
      end
      if ($urandom_range(0, 149) == 0) take_mode = $urandom_range(0, 2);
      if (stall_left == 0 && starts_gap(take_mode)) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build the stimulus, then wait for every result to come back.
  initial begin
    int   n;
    int   phase;
    int   phase_len;
    int   pop_pct;
    int   r;
    int   k;
    logic down;

    for (int i = 0; i < KEY_COUNT; i++) intent_down[i] = 1'b0;

    // Directed: empty pop, both code extremes, repeats that must be ignored,
    // a release of a key that was never down, then drain past empty.
    add_item(kevq_pkg::OP_POP,  1'b0, 8'h00, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b1, 8'h00, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b1, 8'h00, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b1, 8'hff, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b0, 8'h00, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b0, 8'h00, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b0, 8'h80, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b1, 8'haa, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b1, 8'h55, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b0, 8'hff, 1'b0);
    for (int i = 0; i < 7; i++) add_item(kevq_pkg::OP_POP, 1'b1, 8'hff, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b0, 8'haa, 1'b0);
    add_item(kevq_pkg::OP_PUSH, 1'b0, 8'h55, 1'b0);
    add_item(kevq_pkg::OP_POP,  1'b0, 8'h00, 1'b0);
    add_item(kevq_pkg::OP_POP,  1'b1, 8'h00, 1'b0);
    add_item(kevq_pkg::OP_POP,  1'b0, 8'hff, 1'b0);

    // Random: rotate through fill, mixed and drain phases. Fill phases run
    // the ring full, so presses get dropped and releases evict.
    n     = 0;
    phase = 0;
    while (n < 950) begin
      phase_len = $urandom_range(60, 140);
      case (phase % 3)
        0:       pop_pct = 8;
        1:       pop_pct = 50;
        default: pop_pct = 92;
      endcase
      for (int i = 0; i < phase_len && n < 950; i++) begin
        // Pause for a full drain at the first phase and now and then after.
        logic hold;
        hold = (i == 0) && (phase == 0 || $urandom_range(0, 1) == 1);
        if ($urandom_range(0, 99) < pop_pct) begin
          add_item(kevq_pkg::OP_POP, 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), hold);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 60) k = $urandom_range(0, 15);
          else if (r < 70) begin
            case ($urandom_range(0, 3))
              0:       k = 0;
              1:       k = 1;
              2:       k = KEY_COUNT - 2;
              default: k = KEY_COUNT - 1;
            endcase
          end else k = $urandom_range(0, KEY_COUNT - 1);
          // Mostly flip the key; otherwise repeat its state.
          down = ($urandom_range(0, 99) < 85) ? !intent_down[k] : intent_down[k];
          intent_down[k] = down;
          add_item(kevq_pkg::OP_PUSH, down, 8'(k), hold);
        end
        n++;
      end
      phase++;
    end

    while (key_items.size() != 0 || in_valid || items_sent != results_taken)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
